// ===== hw/rtl/tcpq_pkg.sv =====
// Shared constants and types for the three-class priority queue.
`timescale 1ns / 1ps

package tcpq_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int ID_WIDTH    = 16;
	localparam int NUM_CLASSES = 3;

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(NUM_CLASSES * QUEUE_DEPTH);

	// stream payload layout
	localparam int FID_W     = 16;
	localparam int IN_BITS   = 2 + FID_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 1 + 2 + FID_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		CLS_EMERGENCY = 2'd0,
		CLS_PASSENGER = 2'd1,
		CLS_CARGO     = 2'd2
	} fclass_t;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

endpackage

// ===== hw/rtl/three_class_priority_queue_core.sv =====
// Top level: three strict-priority FIFO rings of flight identifiers in one RAM.
// Dequeue path: a dequeue result passes the RAM read register, then the
//   output register; an enqueue gives no result.
// Throughput: one request per cycle; the single RAM takes one write (enqueue)
//   or one read (dequeue) per cycle, and ready drops only under output stall.
// Reset: arst_n clears all ring pointers and counts, so every ring is empty;
//   the identifier RAM is not cleared and no clearing pass runs.
`timescale 1ns / 1ps

module three_class_priority_queue_core
	import tcpq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// request side
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [1:0] flight_class, [17:2] flight_id, pad
	input  logic [0:0]            s_axis_tuser,  // [0] mode
	// result side
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // [0] served, [2:1] served_class,
	                                             // [18:3] served_id, pad
);

	// Ring state per class: read pointer, write pointer, fill count.
	logic [IDX_W-1:0] head_q  [NUM_CLASSES];
	logic [IDX_W-1:0] tail_q  [NUM_CLASSES];
	logic [CNT_W-1:0] count_q [NUM_CLASSES];

	// Dequeue in flight: waits for the RAM read data.
	logic    s1_valid_q;
	logic    s1_served_q;
	fclass_t s1_class_q;

	// Output register.
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic          accept;
	logic          is_deq;
	logic [1:0]    cls_raw;
	logic [FID_W-1:0] fid_in;
	fclass_t       enq_cls;
	fclass_t       deq_cls;
	logic          any_waiting;
	logic          enq_full;
	logic          s1_adv;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ID_WIDTH-1:0] ram_rdata;

	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// ring c lives at offset c * QUEUE_DEPTH
	function automatic logic [ADDR_W-1:0] ring_addr(input fclass_t c,
	                                                input logic [IDX_W-1:0] p);
		return ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
	endfunction

	assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign is_deq  = (s_axis_tuser[0] == MODE_DEQ);
	assign cls_raw = s_axis_tdata[1:0];
	assign fid_in  = s_axis_tdata[2 +: FID_W];

	// class code three falls into cargo
	always_comb begin
		case (cls_raw)
			CLS_EMERGENCY: enq_cls = CLS_EMERGENCY;
			CLS_PASSENGER: enq_cls = CLS_PASSENGER;
			default:       enq_cls = CLS_CARGO;
		endcase
	end

	// strict priority: emergency, then passenger, then cargo
	always_comb begin
		any_waiting = 1'b1;
		if (count_q[CLS_EMERGENCY] != '0) begin
			deq_cls = CLS_EMERGENCY;
		end else if (count_q[CLS_PASSENGER] != '0) begin
			deq_cls = CLS_PASSENGER;
		end else begin
			deq_cls     = CLS_CARGO;
			any_waiting = (count_q[CLS_CARGO] != '0);
		end
	end

	assign enq_full  = (count_q[enq_cls] == CNT_W'(QUEUE_DEPTH));
	assign ram_we    = accept && !is_deq && !enq_full;   // full ring drops the request
	assign ram_waddr = ring_addr(enq_cls, tail_q[enq_cls]);
	assign ram_re    = accept && is_deq && any_waiting;
	assign ram_raddr = ring_addr(deq_cls, head_q[deq_cls]);

	// Read data holds while s1 stalls: no new read is issued until s1 moves.
	tcpq_ram #(
		.WIDTH (ID_WIDTH),
		.DEPTH (NUM_CLASSES * QUEUE_DEPTH)
	) u_id_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ID_WIDTH'(fid_in)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Pointer and count updates; enqueue and dequeue never share a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c]  <= '0;
				tail_q[c]  <= '0;
				count_q[c] <= '0;
			end
		end else begin
			if (ram_we) begin
				tail_q[enq_cls]  <= next_pos(tail_q[enq_cls]);
				count_q[enq_cls] <= count_q[enq_cls] + 1'b1;
			end
			if (ram_re) begin
				head_q[deq_cls]  <= next_pos(head_q[deq_cls]);
				count_q[deq_cls] <= count_q[deq_cls] - 1'b1;
			end
		end
	end

	// Control of the s1 and output stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && is_deq) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload; an empty dequeue reports class 0 and id 0.
	always_ff @(posedge clk) begin
		if (accept && is_deq) begin
			s1_served_q <= any_waiting;
			s1_class_q  <= any_waiting ? deq_cls : CLS_EMERGENCY;
		end
		if (s1_adv) begin
			out_data_q <= OUT_DATA_W'({
				(s1_served_q ? FID_W'(ram_rdata) : FID_W'(0)),
				s1_class_q,
				s1_served_q
			});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/tcpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcpq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/tcpq_checker.sv =====
// Port-level checks for the priority queue core, bound to the top level.
`timescale 1ns / 1ps

module tcpq_checker
	import tcpq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [0:0]            s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// nothing served means class and id are zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_DATA_W-1:1] == '0)
		else $error("empty dequeue result not zero");

	// served class is a real class, pad bits clear
	a_class_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:1] != 2'd3
		&& m_axis_tdata[OUT_DATA_W-1:OUT_BITS] == '0)
		else $error("bad served class or pad");

	// an accepted dequeue request is followed by valid output after the s1 and output stages
	a_deq_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == MODE_DEQ
		|=> ##1 m_axis_tvalid)
		else $error("dequeue result missing");

endmodule

bind three_class_priority_queue_core tcpq_checker u_tcpq_checker (.*);

// ===== dv/three_class_priority_queue_core_checker.sv =====
// Checker: predicts the served flight for each dequeue request and compares results.
`timescale 1ns / 1ps

module three_class_priority_queue_core_checker
	import tcpq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [1:0] flight_class, [17:2] flight_id, pad
	input  logic [0:0]            s_axis_tuser,   // [0] mode
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] served, [2:1] served_class,
	                                              // [18:3] served_id, pad
	output int                    fail_count,
	output int unsigned           results_pending
);

	typedef struct packed {
		logic             served;
		fclass_t          cls;
		logic [FID_W-1:0] fid;
	} served_flight_t;

	// flights waiting in each class ring, oldest first
	logic [FID_W-1:0] waiting_ids [NUM_CLASSES][$];
	served_flight_t   served_expect_q [$];

	initial begin
		fail_count      = 0;
		results_pending = 0;
	end

	function automatic void predict_request(input logic mode, input logic [1:0] cls_code,
	                                        input logic [FID_W-1:0] fid);
		fclass_t        ring;
		served_flight_t rec;
		if (mode == MODE_ENQ) begin
			// anything not emergency or passenger lands in cargo
			case (cls_code)
				CLS_EMERGENCY: ring = CLS_EMERGENCY;
				CLS_PASSENGER: ring = CLS_PASSENGER;
				default:       ring = CLS_CARGO;
			endcase
			if (waiting_ids[ring].size() < QUEUE_DEPTH)
				waiting_ids[ring].push_back(fid);
		end else begin
			rec = '{served: 1'b0, cls: CLS_EMERGENCY, fid: '0};
			for (int c = 0; c < NUM_CLASSES; c++) begin
				if (!rec.served && waiting_ids[c].size() != 0) begin
					rec.served = 1'b1;
					rec.cls    = fclass_t'(c);
					rec.fid    = waiting_ids[c].pop_front();
				end
			end
			served_expect_q.push_back(rec);
		end
	endfunction

	function automatic void check_result(input logic [OUT_DATA_W-1:0] word);
		served_flight_t want;
		if (served_expect_q.size() == 0) begin
			$error("result with no dequeue outstanding: tdata %h", word);
			fail_count++;
			return;
		end
		want = served_expect_q.pop_front();
		if (word[0] !== want.served) begin
			$error("served: expected %0d, actual %0d", want.served, word[0]);
			fail_count++;
		end
		if (word[2:1] !== want.cls) begin
			$error("served_class: expected %0d, actual %0d", want.cls, word[2:1]);
			fail_count++;
		end
		if (word[18:3] !== want.fid) begin
			$error("served_id: expected %h, actual %h", want.fid, word[18:3]);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tuser[0], s_axis_tdata[1:0], s_axis_tdata[17:2]);
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			results_pending <= served_expect_q.size();
		end
	end

endmodule

// ===== dv/three_class_priority_queue_core_test.sv =====
// Testbench top: drives queue requests and result backpressure, gives the verdict.
`timescale 1ns / 1ps

module three_class_priority_queue_core_test;
	import tcpq_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int QUIET_ITEMS  = 300;     // final stretch runs with no idling
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;

	// class code with no ring of its own; the block files it as cargo
	localparam logic [1:0] CLS_CODE_SPARE = 2'd3;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [1:0] flight_class, [17:2] flight_id, pad
	logic [0:0]            s_axis_tuser  = '0;   // [0] mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // [0] served, [2:1] served_class,
	                                             // [18:3] served_id, pad

	int          fail_count;
	int unsigned results_pending;
	int unsigned cycle_count = 0;
	bit          idle_on = 1'b1;  // random gaps and stalls allowed

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	three_class_priority_queue_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	three_class_priority_queue_core_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	// hard stop in case the block hangs or loses a result
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("three_class_priority_queue_core_test: errors");
			$finish;
		end
	end

	// result side: ready high, with random stall bursts while idling is on
	initial begin
		@(posedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	// One request; valid stays high across back-to-back requests and only drops for a gap.
	task automatic send_request(input logic mode, input logic [1:0] cls_code,
	                            input logic [FID_W-1:0] fid);
		if (idle_on && $urandom_range(0, 6) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= IN_DATA_W'({fid, cls_code});
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [FID_W-1:0] any_id();
		return FID_W'($urandom_range(0, 16'hFFFF));
	endfunction

	initial begin
		int          sent;
		int          kind;
		int          phase_len;
		logic        mode;
		logic [1:0]  cls_code;
		logic [1:0]  target;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty dequeue, id extremes, strict priority, spare class code
		send_request(MODE_DEQ, CLS_EMERGENCY, 16'hFFFF);   // all rings empty
		send_request(MODE_ENQ, CLS_CARGO,     16'h0000);
		send_request(MODE_ENQ, CLS_PASSENGER, 16'hFFFF);
		send_request(MODE_ENQ, CLS_CODE_SPARE, 16'h5A5A);  // goes to cargo
		send_request(MODE_ENQ, CLS_EMERGENCY, 16'hAAAA);
		send_request(MODE_ENQ, CLS_EMERGENCY, 16'h5555);
		send_request(MODE_DEQ, CLS_CARGO,     any_id());
		send_request(MODE_DEQ, CLS_CODE_SPARE, any_id());
		send_request(MODE_DEQ, CLS_PASSENGER, any_id());
		// late emergency overtakes waiting cargo
		send_request(MODE_ENQ, CLS_EMERGENCY, 16'h0001);
		send_request(MODE_DEQ, CLS_EMERGENCY, any_id());
		send_request(MODE_DEQ, CLS_EMERGENCY, any_id());
		send_request(MODE_DEQ, CLS_EMERGENCY, any_id());
		send_request(MODE_DEQ, CLS_EMERGENCY, any_id());   // empty again
		send_request(MODE_ENQ, CLS_PASSENGER, 16'h8000);
		send_request(MODE_ENQ, CLS_CARGO,     16'h7FFF);
		send_request(MODE_DEQ, CLS_EMERGENCY, 16'h0000);
		send_request(MODE_DEQ, CLS_EMERGENCY, 16'hFFFF);
		send_request(MODE_DEQ, CLS_EMERGENCY, any_id());

		// random phases: mixed traffic, fill one ring past full, drain everything
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			kind    = $urandom_range(0, 2);
			target  = 2'($urandom_range(0, 2));
			idle_on = (sent < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
			case (kind)
				0:       phase_len = $urandom_range(20, 60);
				1:       phase_len = $urandom_range(QUEUE_DEPTH + 2, QUEUE_DEPTH + 40);
				default: phase_len = $urandom_range(60, 200);
			endcase
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				case (kind)
					0: begin
						mode     = $urandom_range(0, 1) ? MODE_DEQ : MODE_ENQ;
						cls_code = 2'($urandom_range(0, 3));
					end
					1: begin
						// mostly enqueue to one ring so it overflows
						mode     = ($urandom_range(0, 9) == 0) ? MODE_DEQ : MODE_ENQ;
						cls_code = target;
						if (target == CLS_CARGO && $urandom_range(0, 1))
							cls_code = CLS_CODE_SPARE;
						if ($urandom_range(0, 11) == 0)
							cls_code = 2'($urandom_range(0, 3));
					end
					default: begin
						mode     = ($urandom_range(0, 9) == 0) ? MODE_ENQ : MODE_DEQ;
						cls_code = 2'($urandom_range(0, 3));
					end
				endcase
				send_request(mode, cls_code, any_id());
				sent++;
				if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
					idle_on = 1'b0;
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("three_class_priority_queue_core_test: clean");
		else
			$display("three_class_priority_queue_core_test: errors");
		$finish;
	end

endmodule
